FILE: rtl/vpqs_pkg.sv
// Package for the voice prompt queue sequencer: widths, item kinds, register
// indexes, config and command structs. Used by the top level, front end and back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vpqs_pkg;

    // Prompt queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int MS_W    = 8;
    localparam int QCNT_W  = 7;   // queue_count field width on the result stream
    localparam int NCODE_W = 3;   // codes per command, 0..4
    localparam int MAX_CODES = 4;

    localparam logic [MS_W-1:0] MS_MAX = 8'd255;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADD_CODE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_NUM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd3;

    // Register indexes (byte address 4*index)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_DIGIT_ZERO = 2'd0;
    localparam logic [1:0] REG_TEN_WORD   = 2'd1;
    localparam logic [1:0] REG_WARMUP     = 2'd2;
    localparam logic [1:0] REG_OFF_DELAY  = 2'd3;

    // Register reset values
    localparam logic [7:0] RST_DIGIT_ZERO = 8'd0;
    localparam logic [7:0] RST_TEN_WORD   = 8'd10;
    localparam logic [7:0] RST_WARMUP     = 8'd30;
    localparam logic [7:0] RST_OFF_DELAY  = 8'd30;

    typedef struct packed {
        logic [7:0] digit_zero;
        logic [7:0] ten_word;
        logic [7:0] warmup;
        logic [7:0] off_delay;
    } t_cfg;

    // One classified item, as handed from the front end to the executor
    typedef struct packed {
        logic [KIND_W-1:0]                   kind;
        logic                                busy;
        logic [NCODE_W-1:0]                  ncodes;
        logic [MAX_CODES-1:0][CODE_W-1:0]    codes;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/voice_prompt_queue_sequencer.sv
// Voice prompt queue sequencer: top level with config registers, stream port
// packing and the front/back split. Depends on vpqs_pkg, vpqs_front, vpqs_back.
//
// Usage:
//  - Input stream s_axis: tuser carries the item kind (add code, add number,
//    clear, 1 ms tick); tdata carries prompt code, number and player busy.
//  - Result stream m_axis: exactly one result transfer per input transfer, in
//    order: amplifier enable, play strobe, play code and queue fill count.
//  - APB port: four 8-bit registers (digit zero code, ten word code, warm-up
//    and off delay in ms) at byte addresses 0, 4, 8, 12; write only while idle.
// Timing: the executor takes a command from the front queue when it is idle,
// writes its queued codes to the memory one after another (one for add code,
// one to four for add number) or issues the memory read of a popping tick,
// then loads the result register. Only then does it take the next command;
// the front queue keeps taking items meanwhile until it fills, and the single
// memory port makes the codes go in one at a time.
// Reset empties the prompt queue, turns the amplifier off, clears the timer
// and loads the register defaults. When the receiver stalls, the result
// register holds, the executor waits, and the two-entry front queue keeps
// taking items until it fills.
`timescale 1ns / 1ps
`default_nettype none

module voice_prompt_queue_sequencer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input items
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [23:0]                  s_axis_tdata,  // prompt_code, number_value, player_busy
    input  wire logic [1:0]                   s_axis_tuser,  // kind
    // results
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // amp_on, play_valid, play_code, queue_count
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vpqs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    vpqs_pkg::t_cfg r_cfg;
    logic           w_cfg_wr;

    logic           w_cmd_valid;
    logic           w_cmd_ready;
    vpqs_pkg::t_cmd w_cmd;

    logic                          w_amp_on;
    logic                          w_play_valid;
    logic [vpqs_pkg::CODE_W-1:0]   w_play_code;
    logic [vpqs_pkg::QCNT_W-1:0]   w_queue_count;

    // APB register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digit_zero <= vpqs_pkg::RST_DIGIT_ZERO;
            r_cfg.ten_word   <= vpqs_pkg::RST_TEN_WORD;
            r_cfg.warmup     <= vpqs_pkg::RST_WARMUP;
            r_cfg.off_delay  <= vpqs_pkg::RST_OFF_DELAY;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                vpqs_pkg::REG_DIGIT_ZERO: r_cfg.digit_zero <= pwdata[7:0];
                vpqs_pkg::REG_TEN_WORD:   r_cfg.ten_word   <= pwdata[7:0];
                vpqs_pkg::REG_WARMUP:     r_cfg.warmup     <= pwdata[7:0];
                vpqs_pkg::REG_OFF_DELAY:  r_cfg.off_delay  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            vpqs_pkg::REG_DIGIT_ZERO: prdata = {24'd0, r_cfg.digit_zero};
            vpqs_pkg::REG_TEN_WORD:   prdata = {24'd0, r_cfg.ten_word};
            vpqs_pkg::REG_WARMUP:     prdata = {24'd0, r_cfg.warmup};
            vpqs_pkg::REG_OFF_DELAY:  prdata = {24'd0, r_cfg.off_delay};
            default:                  prdata = 32'd0;
        endcase
    end

    vpqs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_kind         (s_axis_tuser),
        .i_prompt_code  (s_axis_tdata[7:0]),
        .i_number_value (s_axis_tdata[15:8]),
        .i_player_busy  (s_axis_tdata[16]),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_ready    (w_cmd_ready)
    );

    vpqs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_ready   (w_cmd_ready),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_amp_on      (w_amp_on),
        .o_play_valid  (w_play_valid),
        .o_play_code   (w_play_code),
        .o_queue_count (w_queue_count)
    );

    // Result packing, lowest bit first
    assign m_axis_tdata = {7'd0, w_queue_count, w_play_code, w_play_valid, w_amp_on};

endmodule

`default_nettype wire

FILE: rtl/vpqs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vpqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/vpqs_front.sv
// Front end: takes input transfers, expands numbers into digit codes and
// buffers classified commands in a two-entry queue. Depends on vpqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpqs_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire vpqs_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [vpqs_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [vpqs_pkg::CODE_W-1:0]  i_prompt_code,
    input  wire logic [7:0]                   i_number_value,
    input  wire logic                         i_player_busy,
    output logic                              o_cmd_valid,
    output vpqs_pkg::t_cmd                    o_cmd,
    input  wire logic                         i_cmd_ready
);

    logic [1:0]     w_hund;
    logic [6:0]     w_rem;
    logic [14:0]    w_prod;
    logic [3:0]     w_tens;
    logic [3:0]     w_units;
    vpqs_pkg::t_cmd w_cmd;

    vpqs_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    // Split the number into decimal digits: hundreds by compare, tens by
    // reciprocal multiply (x*205 >> 11 is exact below 179)
    always_comb begin
        if (i_number_value >= 8'd200) begin
            w_hund = 2'd2;
            w_rem  = 7'(i_number_value - 8'd200);
        end else if (i_number_value >= 8'd100) begin
            w_hund = 2'd1;
            w_rem  = 7'(i_number_value - 8'd100);
        end else begin
            w_hund = 2'd0;
            w_rem  = i_number_value[6:0];
        end
        w_prod  = 15'(w_rem) * 15'd205;
        w_tens  = w_prod[14:11];
        w_units = 4'(w_rem - ({3'b000, w_tens} << 3) - ({3'b000, w_tens} << 1));
    end

    // Build the command: codes to push, in order
    always_comb begin
        w_cmd        = '0;
        w_cmd.kind   = i_kind;
        w_cmd.busy   = i_player_busy;
        case (i_kind)
            vpqs_pkg::KIND_ADD_CODE: begin
                w_cmd.codes[0] = i_prompt_code;
                w_cmd.ncodes   = 3'd1;
            end
            vpqs_pkg::KIND_ADD_NUM: begin
                if (w_hund != 2'd0) begin
                    w_cmd.codes[0] = i_cfg.digit_zero + 8'(w_hund);
                    if (w_rem >= 7'd10) begin
                        w_cmd.codes[1] = i_cfg.digit_zero + 8'(w_tens);
                        w_cmd.codes[2] = i_cfg.ten_word;
                        w_cmd.codes[3] = i_cfg.digit_zero + 8'(w_units);
                        w_cmd.ncodes   = (w_units != 4'd0) ? 3'd4 : 3'd3;
                    end else if (w_rem != 7'd0) begin
                        // zero digit, then the units digit
                        w_cmd.codes[1] = i_cfg.digit_zero;
                        w_cmd.codes[2] = i_cfg.digit_zero + 8'(w_units);
                        w_cmd.ncodes   = 3'd3;
                    end else begin
                        w_cmd.ncodes   = 3'd1;
                    end
                end else if (w_rem >= 7'd10) begin
                    w_cmd.codes[0] = i_cfg.digit_zero + 8'(w_tens);
                    w_cmd.codes[1] = i_cfg.ten_word;
                    w_cmd.codes[2] = i_cfg.digit_zero + 8'(w_units);
                    w_cmd.ncodes   = (w_units != 4'd0) ? 3'd3 : 3'd2;
                end else begin
                    w_cmd.codes[0] = i_cfg.digit_zero + 8'(w_units);
                    w_cmd.ncodes   = 3'd1;
                end
            end
            default: begin
                w_cmd.ncodes = 3'd0;
            end
        endcase
    end

    // Two-entry command queue
    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vpqs_back.sv
// Back end: executes commands against the prompt queue memory, runs the
// amplifier timing on ticks and holds the result register.
// Depends on vpqs_pkg and vpqs_ram.
`timescale 1ns / 1ps
`default_nettype none

module vpqs_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire vpqs_pkg::t_cfg                i_cfg,
    input  wire logic                          i_cmd_valid,
    input  wire vpqs_pkg::t_cmd                i_cmd,
    output logic                               o_cmd_ready,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_amp_on,
    output logic                               o_play_valid,
    output logic [vpqs_pkg::CODE_W-1:0]        o_play_code,
    output logic [vpqs_pkg::QCNT_W-1:0]        o_queue_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PUSH   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam logic [vpqs_pkg::PTR_W-1:0] PTR_LAST = vpqs_pkg::PTR_W'(vpqs_pkg::QUEUE_DEPTH - 1);
    localparam logic [vpqs_pkg::CNT_W-1:0] CNT_FULL = vpqs_pkg::CNT_W'(vpqs_pkg::QUEUE_DEPTH);

    logic [1:0]                    r_state, n_state;
    logic [vpqs_pkg::PTR_W-1:0]    r_rptr, n_rptr, r_wptr, n_wptr;
    logic [vpqs_pkg::CNT_W-1:0]    r_count, n_count;
    logic                          r_amp, n_amp;
    logic [vpqs_pkg::MS_W-1:0]     r_elapsed, n_elapsed;
    vpqs_pkg::t_cmd                r_cmd, n_cmd;
    logic [1:0]                    r_idx, n_idx;
    logic                          r_play, n_play;
    logic [vpqs_pkg::CODE_W-1:0]   r_play_code, n_play_code;

    logic                          r_out_valid, n_out_valid;
    logic                          r_out_amp, n_out_amp;
    logic                          r_out_play, n_out_play;
    logic [vpqs_pkg::CODE_W-1:0]   r_out_code, n_out_code;
    logic [vpqs_pkg::QCNT_W-1:0]   r_out_count, n_out_count;

    logic                          w_we;
    logic [vpqs_pkg::PTR_W-1:0]    w_addr;
    logic [vpqs_pkg::CODE_W-1:0]   w_wdata;
    logic [vpqs_pkg::CODE_W-1:0]   w_rdata;
    logic [vpqs_pkg::MS_W-1:0]     w_ms_inc;

    function automatic logic [vpqs_pkg::PTR_W-1:0] next_ptr(
        input logic [vpqs_pkg::PTR_W-1:0] p
    );
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    vpqs_ram #(
        .WIDTH (vpqs_pkg::CODE_W),
        .DEPTH (vpqs_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_ms_inc    = (r_elapsed == vpqs_pkg::MS_MAX) ? r_elapsed : r_elapsed + 1'b1;

    // Command sequencer
    always_comb begin
        n_state     = r_state;
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_count     = r_count;
        n_amp       = r_amp;
        n_elapsed   = r_elapsed;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_play      = r_play;
        n_play_code = r_play_code;
        n_out_valid = r_out_valid && !i_ready;
        n_out_amp   = r_out_amp;
        n_out_play  = r_out_play;
        n_out_code  = r_out_code;
        n_out_count = r_out_count;
        w_we        = 1'b0;
        w_addr      = r_rptr;
        w_wdata     = r_cmd.codes[r_idx];

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_play = 1'b0;
                    case (i_cmd.kind)
                        vpqs_pkg::KIND_ADD_CODE, vpqs_pkg::KIND_ADD_NUM: begin
                            n_cmd   = i_cmd;
                            n_idx   = 2'd0;
                            n_state = S_PUSH;
                        end
                        vpqs_pkg::KIND_CLEAR: begin
                            n_rptr  = '0;
                            n_wptr  = '0;
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            // tick: advance timer, then amplifier sequencing
                            n_elapsed = w_ms_inc;
                            n_state   = S_DONE;
                            if (!i_cmd.busy) begin
                                if (r_amp) begin
                                    if (r_count == '0) begin
                                        if (w_ms_inc > i_cfg.off_delay) begin
                                            n_amp = 1'b0;
                                        end
                                    end else if (w_ms_inc > i_cfg.warmup) begin
                                        // pop: read issued now, data next cycle
                                        n_rptr    = next_ptr(r_rptr);
                                        n_count   = r_count - 1'b1;
                                        n_elapsed = '0;
                                        n_play    = 1'b1;
                                        n_state   = S_RDWAIT;
                                    end
                                end else if (r_count != '0) begin
                                    n_amp     = 1'b1;
                                    n_elapsed = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_PUSH: begin
                // one code per cycle; full queue drops the oldest entry
                w_we   = 1'b1;
                w_addr = r_wptr;
                n_wptr = next_ptr(r_wptr);
                if (r_count == CNT_FULL) begin
                    n_rptr = next_ptr(r_rptr);
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if ((3'(r_idx) + 3'd1) >= r_cmd.ncodes) begin
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_play_code = w_rdata;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_amp   = r_amp;
                    n_out_play  = r_play;
                    n_out_code  = r_play ? r_play_code : '0;
                    n_out_count = vpqs_pkg::QCNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_amp       <= 1'b0;
            r_elapsed   <= '0;
            r_play      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_count     <= n_count;
            r_amp       <= n_amp;
            r_elapsed   <= n_elapsed;
            r_play      <= n_play;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_play_code <= n_play_code;
        r_out_amp   <= n_out_amp;
        r_out_play  <= n_out_play;
        r_out_code  <= n_out_code;
        r_out_count <= n_out_count;
    end

    assign o_valid       = r_out_valid;
    assign o_amp_on      = r_out_amp;
    assign o_play_valid  = r_out_play;
    assign o_play_code   = r_out_code;
    assign o_queue_count = r_out_count;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue fill count above depth");

    a_play_needs_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_play) |-> r_out_amp)
        else $error("play issued with amplifier off");

    a_rdwait_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDWAIT) |-> ($past(r_state) == S_IDLE && r_play))
        else $error("read wait not entered from a popping tick");

    a_code_zero_no_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_play) |-> (r_out_code == '0))
        else $error("play code not zero without a play");

endmodule

`default_nettype wire
